>>> rtl/path_keyed_hash_table_core_defines.svh
// Assertion macros for the path keyed hash table core.
`ifndef PATH_KEYED_HASH_TABLE_CORE_DEFINES_SVH
`define PATH_KEYED_HASH_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PKHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pkht check failed");
// next-cycle implication
`define PKHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pkht check failed");
`else
`define PKHT_ASSERT_NOW(label, ante, cons)
`define PKHT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/pkht_pkg.sv
`timescale 1ns / 1ps
package pkht_pkg;
  localparam int TABLE_SLOTS = 256;
  localparam int NAME_BYTES  = 72;
  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int KLEN_W  = $clog2(NAME_BYTES);
  localparam int NAME_W  = $clog2(TABLE_SLOTS * NAME_BYTES);
  localparam int COUNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int ENTRY_W = 9;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] ACT_KEY    = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_REJECTED = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  key_byte;
    logic [31:0] file_size;
    logic [15:0] file_mode;
  } pkht_item_t;

  // operation handed from front to back
  typedef struct packed {
    logic [1:0]        action;
    logic              reject;
    logic [31:0]       hash;
    logic [KLEN_W-1:0] len;
    logic [31:0]       file_size;
    logic [15:0]       file_mode;
  } pkht_op_t;

  typedef struct packed {
    logic [31:0]       hash;
    logic [31:0]       size;
    logic [15:0]       mode;
    logic [KLEN_W-1:0] len;
  } pkht_meta_t;

  typedef struct packed {
    logic busy;   // back is reading the key buffer
    logic take;   // back takes the queued operation
  } pkht_back_st_t;
endpackage

>>> rtl/pkht_ram.sv
`timescale 1ns / 1ps
module pkht_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/pkht_front.sv
`timescale 1ns / 1ps
module pkht_front import pkht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pkht_item_t        in_item,
  input  pkht_back_st_t     back_st,
  output logic              q_valid,
  output pkht_op_t          q,
  output logic              kb_we,
  output logic [KLEN_W-1:0] kb_waddr,
  output logic [7:0]        kb_wdata
);
  localparam logic [1:0] PH_STRIP = 2'd0;
  localparam logic [1:0] PH_DOT   = 2'd1;
  localparam logic [1:0] PH_COPY  = 2'd2;

  logic [KLEN_W-1:0] key_len, key_len_next;
  logic [31:0]       key_hash, key_hash_next;
  logic [1:0]        phase, phase_next;
  logic              overflow, overflow_next;
  logic              hold_valid;
  pkht_item_t        hold;
  logic              q_valid_next;

  pkht_item_t  src;
  logic        go, do_app, hold_set, enq;
  logic [7:0]  app_c, c;
  logic [31:0] mix;

  assign full = hold_valid | q_valid | back_st.busy;

  always_comb begin
    src = hold_valid ? hold : in_item;
    go = hold_valid | (push & ~full);
    key_len_next = key_len;
    key_hash_next = key_hash;
    phase_next = phase;
    overflow_next = overflow;
    do_app = 1'b0;
    app_c = src.key_byte;
    hold_set = 1'b0;
    enq = 1'b0;
    kb_we = 1'b0;
    if (go) begin
      if (src.action == ACT_KEY) begin
        if (src.key_byte != 8'd0) begin
          case (phase)
            PH_STRIP: begin
              if (src.key_byte == 8'h2E) begin
                phase_next = PH_DOT;
              end else if (src.key_byte != 8'h2F) begin
                do_app = 1'b1;
                phase_next = PH_COPY;
              end
            end
            PH_DOT: begin
              if (src.key_byte == 8'h2F) begin
                phase_next = PH_STRIP;
              end else begin
                do_app = 1'b1;
                app_c = 8'h2E;
                hold_set = 1'b1;
                phase_next = PH_COPY;
              end
            end
            default: begin
              do_app = 1'b1;
            end
          endcase
        end
      end else if (phase == PH_DOT) begin
        // held-back dot is kept before the operation
        do_app = 1'b1;
        app_c = 8'h2E;
        hold_set = 1'b1;
        phase_next = PH_COPY;
      end else begin
        enq = 1'b1;
      end
    end
    c = app_c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'd32;
    end
    if (c == 8'h5C) begin
      c = 8'h2F;
    end
    mix = key_hash ^ {24'd0, c};
    if (do_app) begin
      if (32'(key_len) >= 32'(NAME_BYTES - 1)) begin
        overflow_next = 1'b1;
      end else begin
        kb_we = 1'b1;
        key_len_next = key_len + 1'b1;
        key_hash_next = mix * FNV_PRIME;
      end
    end
    if (enq) begin
      key_len_next = '0;
      key_hash_next = FNV_BASIS;
      phase_next = PH_STRIP;
      overflow_next = 1'b0;
    end
    q_valid_next = (q_valid & ~back_st.take) | enq;
  end

  assign kb_waddr = key_len;
  assign kb_wdata = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      key_hash <= FNV_BASIS;
      phase <= PH_STRIP;
      overflow <= 1'b0;
      hold_valid <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      key_len <= key_len_next;
      key_hash <= key_hash_next;
      phase <= phase_next;
      overflow <= overflow_next;
      hold_valid <= hold_set;
      q_valid <= q_valid_next;
    end
    if (hold_set) begin
      hold <= src;
    end
    if (enq) begin
      q.action <= src.action;
      q.reject <= (key_len == '0) | overflow;
      q.hash <= (key_hash == 32'd0) ? 32'd1 : key_hash;
      q.len <= key_len;
      q.file_size <= src.file_size;
      q.file_mode <= src.file_mode;
    end
  end
endmodule

>>> rtl/pkht_back.sv
`timescale 1ns / 1ps
module pkht_back import pkht_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pkht_op_t           q,
  output pkht_back_st_t      back_st,
  output logic [KLEN_W-1:0]  kb_raddr,
  input  logic [7:0]         kb_rdata,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [31:0]        found_size,
  output logic [15:0]        found_mode,
  output logic [ENTRY_W-1:0] entry_count
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_META  = 3'd2;
  localparam logic [2:0] S_BRD   = 3'd3;
  localparam logic [2:0] S_BCMP  = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_CWR   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(TABLE_SLOTS - 1);

  logic [2:0]             state;
  pkht_op_t               op;
  logic [SLOT_W-1:0]      idx, start, nidx;
  logic [KLEN_W-1:0]      bi;
  logic [TABLE_SLOTS-1:0] used;
  logic [COUNT_W-1:0]     count;
  logic [2:0]             res_status;
  logic [31:0]            res_size;
  logic [15:0]            res_mode;
  logic                   out_valid;

  logic              meta_we, name_we;
  pkht_meta_t        meta_wdata, meta_rdata;
  logic [NAME_W-1:0] name_addr;
  logic [7:0]        name_rdata;

  assign nidx = (idx + 1'b1) & SLOT_MASK;
  assign name_addr = NAME_W'(idx) * NAME_W'(NAME_BYTES) + NAME_W'(bi);
  assign kb_raddr = bi;
  assign back_st.busy = (state != S_IDLE) && (state != S_DONE);
  assign back_st.take = (state == S_IDLE) && q_valid;

  always_comb begin
    meta_we = 1'b0;
    meta_wdata.hash = op.hash;
    meta_wdata.size = op.file_size;
    meta_wdata.mode = op.file_mode;
    meta_wdata.len = op.len;
    if (state == S_PROBE && !used[idx] && op.action == ACT_INSERT) begin
      meta_we = 1'b1;
    end
    if (state == S_BCMP && kb_rdata == name_rdata && bi == op.len - 1'b1 &&
        op.action == ACT_INSERT) begin
      meta_we = 1'b1;
      meta_wdata.hash = meta_rdata.hash;
      meta_wdata.len = meta_rdata.len;
    end
    name_we = (state == S_CWR);
  end

  pkht_ram #(.WIDTH($bits(pkht_meta_t)), .DEPTH(TABLE_SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (idx),
    .wdata (meta_wdata),
    .raddr (idx),
    .rdata (meta_rdata)
  );

  pkht_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * NAME_BYTES)) u_names (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_addr),
    .wdata (kb_rdata),
    .raddr (name_addr),
    .rdata (name_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op <= q;
            idx <= q.hash[SLOT_W-1:0];
            start <= q.hash[SLOT_W-1:0];
            res_size <= '0;
            res_mode <= '0;
            if (q.reject) begin
              res_status <= ST_REJECTED;
              state <= S_DONE;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (!used[idx]) begin
            if (op.action == ACT_INSERT) begin
              used[idx] <= 1'b1;
              bi <= '0;
              state <= S_CRD;
            end else begin
              res_status <= ST_MISSING;
              state <= S_DONE;
            end
          end else begin
            state <= S_META;
          end
        end
        S_META: begin
          if (meta_rdata.hash == op.hash && meta_rdata.len == op.len) begin
            bi <= '0;
            state <= S_BRD;
          end else if (nidx == start) begin
            res_status <= (op.action == ACT_INSERT) ? ST_FULL : ST_MISSING;
            state <= S_DONE;
          end else begin
            idx <= nidx;
            state <= S_PROBE;
          end
        end
        S_BRD: begin
          state <= S_BCMP;
        end
        S_BCMP: begin
          if (kb_rdata != name_rdata) begin
            if (nidx == start) begin
              res_status <= (op.action == ACT_INSERT) ? ST_FULL : ST_MISSING;
              state <= S_DONE;
            end else begin
              idx <= nidx;
              state <= S_PROBE;
            end
          end else if (bi == op.len - 1'b1) begin
            state <= S_DONE;
            case (op.action)
              ACT_INSERT: res_status <= ST_UPDATED;
              ACT_REMOVE: begin
                used[idx] <= 1'b0;
                count <= count - 1'b1;
                res_status <= ST_REMOVED;
              end
              default: begin
                res_size <= meta_rdata.size;
                res_mode <= meta_rdata.mode;
                res_status <= ST_FOUND;
              end
            endcase
          end else begin
            bi <= bi + 1'b1;
            state <= S_BRD;
          end
        end
        S_CRD: begin
          state <= S_CWR;
        end
        S_CWR: begin
          if (bi == op.len - 1'b1) begin
            count <= count + 1'b1;
            res_status <= ST_INSERTED;
            state <= S_DONE;
          end else begin
            bi <= bi + 1'b1;
            state <= S_CRD;
          end
        end
        default: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            status <= res_status;
            found_size <= res_size;
            found_mode <= res_mode;
            entry_count <= ENTRY_W'(count);
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign empty = ~out_valid;
endmodule

>>> rtl/path_keyed_hash_table_core.sv
// Path keyed hash table core: open addressing, linear probing, FNV-1a 32 hash.
// Input queue side: push/full. Each transfer carries action, key_byte,
// file_size and file_mode. Key-byte transfers (action 0) build the key; an
// operation transfer (insert/update, remove, lookup) ends it.
// Result queue side: empty/pop. One result per operation, none per key byte.
// The front end takes key bytes back to back, but a byte that follows a
// held-back dot is held while the dot is emitted. An operation walks the
// back end states: per slot probed, a probe and a metadata check; per byte
// of a name compare or insert copy, a name memory read, then a compare or
// write. Rejected keys skip the probe. full is held while a byte is held
// back, an operation is queued or the back end still reads the key buffer.
// Reset clears all slot valid flags, the entry count and the key collector;
// no memory clearing pass is needed.
// A stalled receiver (pop low) holds the result register; the back end
// finishes its next operation and then waits until the register drains.
`timescale 1ns / 1ps
`include "path_keyed_hash_table_core_defines.svh"
module path_keyed_hash_table_core import pkht_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [7:0]         key_byte,
  input  logic [31:0]        file_size,
  input  logic [15:0]        file_mode,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [31:0]        found_size,
  output logic [15:0]        found_mode,
  output logic [ENTRY_W-1:0] entry_count
);
  pkht_item_t        in_item;
  pkht_back_st_t     back_st;
  logic              q_valid;
  pkht_op_t          q;
  logic              kb_we;
  logic [KLEN_W-1:0] kb_waddr, kb_raddr;
  logic [7:0]        kb_wdata, kb_rdata;

  assign in_item.action = action;
  assign in_item.key_byte = key_byte;
  assign in_item.file_size = file_size;
  assign in_item.file_mode = file_mode;

  // front: strip, normalise, hash; one-entry queue to the back
  pkht_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .back_st  (back_st),
    .q_valid  (q_valid),
    .q        (q),
    .kb_we    (kb_we),
    .kb_waddr (kb_waddr),
    .kb_wdata (kb_wdata)
  );

  // key buffer: written by the front, read by the back
  pkht_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_keybuf (
    .clk   (clk),
    .we    (kb_we),
    .waddr (kb_waddr),
    .wdata (kb_wdata),
    .raddr (kb_raddr),
    .rdata (kb_rdata)
  );

  // back: probe, compare, insert copy, result register
  pkht_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q           (q),
    .back_st     (back_st),
    .kb_raddr    (kb_raddr),
    .kb_rdata    (kb_rdata),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .found_size  (found_size),
    .found_mode  (found_mode),
    .entry_count (entry_count)
  );

  // key buffer must not change while the back end reads it
  `PKHT_ASSERT_NOW(a_busy_full, back_st.busy, full)
  // only a lookup hit carries size and mode
  `PKHT_ASSERT_NOW(a_found_zero, !empty && status != ST_FOUND,
    found_size == 32'd0 && found_mode == 16'd0)
  `PKHT_ASSERT_NOW(a_count_range, !empty, entry_count <= ENTRY_W'(TABLE_SLOTS))
  // a taken operation leaves the queue on the next edge
  `PKHT_ASSERT_NEXT(a_take_drains, back_st.take, !q_valid)
endmodule

>>> tb/path_keyed_hash_table_core_test.sv
`timescale 1ns / 1ps
module path_keyed_hash_table_core_test;
  import pkht_pkg::*;

  // key collector phases: leading slashes, a '.' held back, copying
  typedef enum logic [1:0] {PH_SLASH, PH_DOT, PH_COPY} strip_phase_t;

  typedef struct {
    logic [2:0]         status;
    logic [31:0]        size;
    logic [15:0]        mode;
    logic [ENTRY_W-1:0] count;
  } table_reply_t;

  localparam int HOLDOFF_CYCLES = 400;  // long receiver stall
  localparam int IDLE_LIMIT     = 3000; // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         action = ACT_KEY;
  logic [7:0]         key_byte = 8'd0;
  logic [31:0]        file_size = 32'd0;
  logic [15:0]        file_mode = 16'd0;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         status;
  logic [31:0]        found_size;
  logic [15:0]        found_mode;
  logic [ENTRY_W-1:0] entry_count;

  path_keyed_hash_table_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .key_byte(key_byte), .file_size(file_size), .file_mode(file_mode),
    .empty(empty), .pop(pop), .status(status), .found_size(found_size),
    .found_mode(found_mode), .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table shadow: our own copy of slots and the key collector
  // ---------------------------------------------------------------------------
  logic               shadow_used [TABLE_SLOTS];
  logic [31:0]        shadow_hash [TABLE_SLOTS];
  logic [31:0]        shadow_size [TABLE_SLOTS];
  logic [15:0]        shadow_mode [TABLE_SLOTS];
  int                 shadow_len  [TABLE_SLOTS];
  logic [7:0]         shadow_name [TABLE_SLOTS][NAME_BYTES];
  logic [7:0]         key_buf [NAME_BYTES];
  int                 key_len;
  logic [31:0]        key_fnv;
  strip_phase_t       key_phase;
  logic               key_too_long;
  int                 entries;

  table_reply_t       replies_due[$];   // expected results, oldest first
  int                 errors = 0;
  bit                 holdoff_req = 1'b0;
  int                 idle_cycles = 0;

  function automatic void restart_key();
    key_len      = 0;
    key_fnv      = FNV_BASIS;
    key_phase    = PH_SLASH;
    key_too_long = 1'b0;
  endfunction

  // normalise and hash one kept byte
  function automatic void keep_byte(logic [7:0] c);
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    if (c == "\\") c = "/";
    if (key_len >= NAME_BYTES - 1) begin
      key_too_long = 1'b1;
      return;
    end
    key_buf[key_len] = c;
    key_len++;
    key_fnv = (key_fnv ^ {24'd0, c}) * FNV_PRIME;
  endfunction

  function automatic void collect_byte(logic [7:0] b);
    if (b == 8'd0) return;  // zero byte: no effect at all
    case (key_phase)
      PH_SLASH: begin
        if (b == "/") ;
        else if (b == ".") key_phase = PH_DOT;
        else begin
          keep_byte(b);
          key_phase = PH_COPY;
        end
      end
      PH_DOT: begin
        if (b == "/") key_phase = PH_SLASH;  // "./" group dropped
        else begin
          keep_byte(".");
          keep_byte(b);
          key_phase = PH_COPY;
        end
      end
      default: keep_byte(b);
    endcase
  endfunction

  // 0 hit, 1 free slot, 2 wrapped round without a hit
  function automatic int probe_table(logic [31:0] h, output int slot);
    int idx;
    int start;
    bit same;
    idx   = h & (TABLE_SLOTS - 1);
    start = idx;
    while (shadow_used[idx]) begin
      if (shadow_hash[idx] == h && shadow_len[idx] == key_len) begin
        same = 1'b1;
        for (int i = 0; i < key_len; i++)
          if (shadow_name[idx][i] != key_buf[i]) same = 1'b0;
        if (same) begin
          slot = idx;
          return 0;
        end
      end
      idx = (idx + 1) % TABLE_SLOTS;
      if (idx == start) begin
        slot = idx;
        return 2;
      end
    end
    slot = idx;
    return 1;
  endfunction

  function automatic table_reply_t apply_operation(logic [1:0] act, logic [31:0] sz,
                                                   logic [15:0] md);
    table_reply_t r;
    logic [31:0]  h;
    int           slot;
    int           hit;
    r.size = '0;
    r.mode = '0;
    if (key_phase == PH_DOT) keep_byte(".");  // trailing dot is kept
    if (key_len == 0 || key_too_long) r.status = ST_REJECTED;
    else begin
      h   = (key_fnv == 32'd0) ? 32'd1 : key_fnv;
      hit = probe_table(h, slot);
      case (act)
        ACT_INSERT: begin
          if (hit == 0) begin
            shadow_size[slot] = sz;
            shadow_mode[slot] = md;
            r.status = ST_UPDATED;
          end else if (hit == 1) begin
            shadow_used[slot] = 1'b1;
            shadow_hash[slot] = h;
            shadow_size[slot] = sz;
            shadow_mode[slot] = md;
            shadow_len[slot]  = key_len;
            for (int i = 0; i < key_len; i++) shadow_name[slot][i] = key_buf[i];
            entries++;
            r.status = ST_INSERTED;
          end else r.status = ST_FULL;
        end
        ACT_REMOVE: begin
          if (hit == 0) begin
            shadow_used[slot] = 1'b0;  // no tombstone
            if (entries > 0) entries--;
            r.status = ST_REMOVED;
          end else r.status = ST_MISSING;
        end
        default: begin
          if (hit == 0) begin
            r.size   = shadow_size[slot];
            r.mode   = shadow_mode[slot];
            r.status = ST_FOUND;
          end else r.status = ST_MISSING;
        end
      endcase
    end
    restart_key();
    r.count = entries[ENTRY_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, random gap before it
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [1:0] act, logic [7:0] b, logic [31:0] sz, logic [15:0] md);
    int  gap;
    bit  taken;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    action    <= act;
    key_byte  <= b;
    file_size <= sz;
    file_mode <= md;
    // full only moves at the rising edge, so its value at the falling edge
    // is what the next edge will see
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    if (act == ACT_KEY) collect_byte(b);
    else replies_due.push_back(apply_operation(act, sz, md));
  endtask

  task automatic send_key(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(ACT_KEY, s[i], $urandom, 16'($urandom_range(16'hffff)));
  endtask

  task automatic send_op(logic [1:0] act, logic [31:0] sz = $urandom,
                         logic [15:0] md = 16'($urandom_range(16'hffff)));
    send_item(act, 8'($urandom_range(255)), sz, md);
  endtask

  task automatic keyed_op(string s, logic [1:0] act);
    send_key(s);
    send_op(act);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls, compare each transfer
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
    errors++;
  endtask

  initial begin : result_checker
    int           stall;
    bit           taken;
    table_reply_t seen;
    table_reply_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_req) begin
        pop <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end
      stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        taken       = !empty;
        seen.status = status;
        seen.size   = found_size;
        seen.mode   = found_mode;
        seen.count  = entry_count;
        @(posedge clk);
      end while (!taken);
      if (replies_due.size() == 0) begin
        $display("unexpected result at %0t: status %0d", $realtime, seen.status);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (seen.status !== want.status) report_mismatch("status", seen.status, want.status);
        if (seen.size !== want.size) report_mismatch("found_size", seen.size, want.size);
        if (seen.mode !== want.mode) report_mismatch("found_mode", seen.mode, want.mode);
        if (seen.count !== want.count) report_mismatch("entry_count", seen.count, want.count);
      end
    end
  end

  // watchdog: ends the run after too long without any transfer
  always @(negedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // sender pause until every expected result has arrived
  task automatic wait_drained();
    push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_key_forms();
    string long_key;
    send_op(ACT_INSERT);                     // empty key
    keyed_op("///", ACT_INSERT);             // only slashes
    keyed_op("././/", ACT_LOOKUP);           // only dot groups
    send_key("A\\B");                        // case fold, backslash
    send_op(ACT_INSERT, 32'hffff_ffff, 16'hffff);
    keyed_op("//././/a/B", ACT_LOOKUP);      // same name after stripping
    send_key("a/b");
    send_op(ACT_INSERT, 32'd0, 16'd0);       // update to zero
    keyed_op("A/B", ACT_LOOKUP);
    keyed_op(".", ACT_INSERT);               // trailing held dot kept
    keyed_op("..", ACT_LOOKUP);              // ".." is a name of its own
    keyed_op("/.", ACT_LOOKUP);
    keyed_op("\\x", ACT_INSERT);             // backslash not stripped
    send_item(ACT_KEY, 8'd0, '0, '0);        // zero bytes ignored
    send_key("/x");
    send_item(ACT_KEY, 8'd0, '1, '1);
    send_op(ACT_LOOKUP);
    long_key = "";
    repeat (NAME_BYTES - 1) long_key = {long_key, "z"};
    keyed_op(long_key, ACT_INSERT);          // longest legal key
    keyed_op({long_key, "z"}, ACT_INSERT);   // one over: rejected
    keyed_op("nothere", ACT_REMOVE);
    keyed_op("a/b", ACT_REMOVE);
    keyed_op("a/b", ACT_LOOKUP);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < TABLE_SLOTS + 1; i++)
      keyed_op($sformatf("%02x", i), ACT_INSERT);   // last ones find it full
    keyed_op("missing", ACT_LOOKUP);                 // probe wraps round
    keyed_op("07", ACT_LOOKUP);
    keyed_op("07", ACT_INSERT);
    wait_drained();
    for (int i = 0; i < 16; i++)
      keyed_op($sformatf("%02X", i * 16 + 10), ACT_REMOVE);
    keyed_op("/", ACT_REMOVE);
    keyed_op(".", ACT_REMOVE);
    keyed_op("\\x", ACT_REMOVE);
    wait_drained();
  endtask

  task automatic test_backpressure();
    holdoff_req = 1'b1;
    for (int i = 0; i < 24; i++) keyed_op($sformatf("p%0d", i % 6), 2'(i % 3 + 1));
    wait_drained();
  endtask

  function automatic string decorate(string base);
    string s;
    s = "";
    repeat ($urandom_range(2)) s = {s, "/"};
    repeat ($urandom_range(2)) s = {s, "./"};
    for (int i = 0; i < base.len(); i++) begin
      if (base[i] == "/" && $urandom_range(3) == 0) s = {s, "\\"};
      else if (base[i] >= "a" && base[i] <= "z" && $urandom_range(1))
        s = {s, string'(base[i] - 8'd32)};
      else s = {s, string'(base[i])};
    end
    return s;
  endfunction

  task automatic test_random_traffic();
    int n;
    for (int op = 0; op < 15; op++) begin
      if ($urandom_range(9) == 0) begin
        // noise: random raw bytes, sometimes a key past the limit
        n = ($urandom_range(7) == 0) ? NAME_BYTES + $urandom_range(3) : $urandom_range(5);
        repeat (n) send_item(ACT_KEY, 8'($urandom_range(255)), $urandom,
                             16'($urandom_range(16'hffff)));
        send_op(2'($urandom_range(ACT_LOOKUP, ACT_INSERT)));
      end else begin
        n = $urandom_range(15);
        send_key(decorate($sformatf("d%0d/f%0d", n % 3, n)));
        if ($urandom_range(7) == 0)
          send_item(ACT_KEY, 8'd0, $urandom, 16'($urandom_range(16'hffff)));
        send_op(2'($urandom_range(ACT_LOOKUP, ACT_INSERT)));
      end
    end
    wait_drained();
  endtask

  initial begin : run
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_used[i] = 1'b0;
    entries = 0;
    restart_key();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_key_forms();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> path_keyed_hash_table_core.f
+incdir+rtl
rtl/pkht_pkg.sv
rtl/pkht_ram.sv
rtl/pkht_front.sv
rtl/pkht_back.sv
rtl/path_keyed_hash_table_core.sv
tb/path_keyed_hash_table_core_test.sv
